// ===== rtl/bfg_pkg.sv =====
// Package for the grayscale bilateral filter.
// Holds item types, register and kind codes, controller states and the
// command and status structs. No dependencies.
package bfg_pkg;

  // Fixed field and register widths.
  localparam int CFG_W        = 13;
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 13;
  localparam int RADIUS_W     = 3;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RANGE_LEVELS = 256;
  localparam int CNT_W        = 4;
  localparam int FLUSH_CYCLES = 4;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_SPATIAL = 2'd1,
    KIND_RANGE   = 2'd2,
    KIND_DRAIN   = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel_value;
    logic [7:0]  table_index;
    logic [15:0] weight_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       filtered_pixel;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CENTRE,
    ST_BACK,
    ST_BACK_COL,
    ST_TAPS,
    ST_FLUSH,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       start;
    logic       back_row;
    logic       back_col;
    logic       tap;
    logic       tap_row_end;
    logic       div_step;
    logic [2:0] div_bit;
    logic       emit;
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic                emit_ok;
    logic [RADIUS_W-1:0] radius;
    logic                out_block;
  } dp_status_t;

endpackage

// ===== rtl/bfg_stream_if.sv =====
// Valid/ready stream interface used by the bilateral filter channels.
// The payload type is a parameter; no other dependencies.
interface bfg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bfg_ctrl.sv =====
// Controller state machine of the bilateral filter.
// Sequences the window walk, pipeline flush, division and result handoff.
// Depends on bfg_pkg.
module bfg_ctrl import bfg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  kind_t      accept_kind,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       in_ready
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt_x;
  logic [CNT_W-1:0] cnt_y;
  logic [2:0]       div_cnt;
  logic [CNT_W-1:0] span;
  logic             row_end;

  assign span    = {status.radius, 1'b0};
  assign row_end = (cnt_x == span);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (accept_kind inside {KIND_PIXEL, KIND_DRAIN})) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK:    state_next = status.emit_ok ? ST_CENTRE : ST_IDLE;
      ST_CENTRE:   state_next = (status.radius == '0) ? ST_BACK_COL : ST_BACK;
      ST_BACK: begin
        if (cnt_x == CNT_W'(status.radius) - CNT_W'(1)) begin
          state_next = ST_BACK_COL;
        end
      end
      ST_BACK_COL: state_next = ST_TAPS;
      ST_TAPS: begin
        if (row_end && cnt_y == span) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (cnt_x == CNT_W'(FLUSH_CYCLES - 1)) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.out_block) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // State register and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt_x   <= '0;
      cnt_y   <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CENTRE:   cnt_x <= '0;
        ST_BACK:     cnt_x <= cnt_x + CNT_W'(1);
        ST_BACK_COL: begin
          cnt_x <= '0;
          cnt_y <= '0;
        end
        ST_TAPS: begin
          if (row_end) begin
            cnt_x <= '0;
            cnt_y <= cnt_y + CNT_W'(1);
          end else begin
            cnt_x <= cnt_x + CNT_W'(1);
          end
        end
        ST_FLUSH: begin
          cnt_x   <= cnt_x + CNT_W'(1);
          div_cnt <= 3'd7;
        end
        ST_DIVIDE:   div_cnt <= div_cnt - 3'd1;
        default:     ;
      endcase
    end
  end

  // Command outputs.
  always_comb begin
    in_ready        = (state == ST_IDLE);
    cmd.start       = (state == ST_CENTRE);
    cmd.back_row    = (state == ST_BACK);
    cmd.back_col    = (state == ST_BACK_COL);
    cmd.tap         = (state == ST_TAPS);
    cmd.tap_row_end = row_end;
    cmd.div_step    = (state == ST_DIVIDE);
    cmd.div_bit     = div_cnt;
    cmd.emit        = (state == ST_EMIT) && !status.out_block;
  end

endmodule

// ===== rtl/bfg_datapath.sv =====
// Datapath of the bilateral filter: configuration, line store, weight
// tables, tap address walk, multiply-accumulate pipeline, restoring divider
// and output register. Depends on bfg_pkg.
module bfg_datapath import bfg_pkg::*; #(
  parameter int MAX_RADIUS = 4,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  in_item_t        item,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  ctrl_cmd_t       cmd,
  output dp_status_t      status,
  input  logic            out_ready,
  output logic            out_valid,
  output out_item_t       out_item
);

  localparam int KSIDE      = 2 * MAX_RADIUS + 1;
  localparam int KSQ        = KSIDE * KSIDE;
  localparam int LINE_DEPTH = KSIDE * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int SIDX_W     = $clog2(KSQ);
  localparam int SXY_W      = $clog2(KSIDE);
  localparam int TOT_W      = 32 + $clog2(KSQ);
  localparam int SUM_W      = TOT_W + 8;

  // Ring address arithmetic, both operands below the store depth.
  function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W+1)'(LINE_DEPTH)) s = s - (ADDR_W+1)'(LINE_DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mod_sub(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + (ADDR_W+1)'(LINE_DEPTH) - {1'b0, b};
    return s[ADDR_W-1:0];
  endfunction

  // Configuration registers and effective values.
  logic [WIDTH_W-1:0]  width_cfg;
  logic [HEIGHT_W-1:0] height_cfg;
  logic [RADIUS_W-1:0] radius_cfg;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [RADIUS_W-1:0] rad;
  logic                cfg_hit;

  assign cfg_hit = cfg_wr_en && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_RADIUS});

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= WIDTH_W'(640);
      height_cfg <= HEIGHT_W'(480);
      radius_cfg <= RADIUS_W'(2);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:  width_cfg  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_cfg <= cfg_data[HEIGHT_W-1:0];
        REG_RADIUS: radius_cfg <= cfg_data[RADIUS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (width_cfg == '0)                  w_eff = WIDTH_W'(1);
    else if (32'(width_cfg) > MAX_WIDTH)  w_eff = WIDTH_W'(MAX_WIDTH);
    else                                  w_eff = width_cfg;
    if (height_cfg == '0)                 h_eff = HEIGHT_W'(1);
    else if (32'(height_cfg) > MAX_HEIGHT) h_eff = HEIGHT_W'(MAX_HEIGHT);
    else                                  h_eff = height_cfg;
    if (32'(radius_cfg) > MAX_RADIUS)     rad = RADIUS_W'(MAX_RADIUS);
    else                                  rad = radius_cfg;
  end

  // Input and output raster positions. Columns are counted at the full
  // register width so any built line width fits; the result carries the
  // low bits.
  logic [ROW_W-1:0]    in_row, o_row;
  logic [WIDTH_W-1:0]  in_col, o_col;
  logic [ADDR_W-1:0]   in_addr, o_addr;
  logic                frame_received;
  logic                pix_wr;
  logic                last;
  logic                restart;
  logic [WIDTH_W-1:0]  wm1;
  logic [HEIGHT_W-1:0] hm1;

  assign wm1     = w_eff - WIDTH_W'(1);
  assign hm1     = h_eff - HEIGHT_W'(1);
  assign pix_wr  = accept && item.kind == KIND_PIXEL && !frame_received;
  assign last    = (HEIGHT_W'(o_row) == hm1) && (o_col == wm1);
  assign restart = cfg_hit || (cmd.emit && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row         <= '0;
      in_col         <= '0;
      in_addr        <= '0;
      frame_received <= 1'b0;
      o_row          <= '0;
      o_col          <= '0;
      o_addr         <= '0;
    end else if (restart) begin
      in_row         <= '0;
      in_col         <= '0;
      in_addr        <= '0;
      frame_received <= 1'b0;
      o_row          <= '0;
      o_col          <= '0;
      o_addr         <= '0;
    end else begin
      if (pix_wr) begin
        in_addr <= mod_add(in_addr, ADDR_W'(1));
        if (in_col == wm1) begin
          in_col <= '0;
          if (HEIGHT_W'(in_row) == hm1) begin
            in_row         <= '0;
            frame_received <= 1'b1;
          end else begin
            in_row <= in_row + ROW_W'(1);
          end
        end else begin
          in_col <= in_col + WIDTH_W'(1);
        end
      end
      if (cmd.emit) begin
        o_addr <= mod_add(o_addr, ADDR_W'(1));
        if (o_col == wm1) begin
          o_col <= '0;
          o_row <= o_row + ROW_W'(1);
        end else begin
          o_col <= o_col + WIDTH_W'(1);
        end
      end
    end
  end

  // Readiness: the lower right tap of the window has arrived.
  logic [HEIGHT_W-1:0] lr_sum, lr;
  logic [WIDTH_W:0]    lc_sum, lc;

  always_comb begin
    lr_sum = HEIGHT_W'(o_row) + HEIGHT_W'(rad);
    lc_sum = (WIDTH_W+1)'(o_col) + (WIDTH_W+1)'(rad);
    lr     = (lr_sum > hm1) ? hm1 : lr_sum;
    lc     = (lc_sum > (WIDTH_W+1)'(wm1)) ? (WIDTH_W+1)'(wm1) : lc_sum;
    status.emit_ok = frame_received || (lr < HEIGHT_W'(in_row)) ||
                     (lr == HEIGHT_W'(in_row) && lc < (WIDTH_W+1)'(in_col));
    status.radius  = rad;
    status.out_block = out_valid && !out_ready;
  end

  // Window walk registers.
  logic [ADDR_W-1:0]        base, row_addr, tap_addr, line_rd_addr;
  logic signed [ROW_W+1:0]  t_row;
  logic signed [WIDTH_W:0]  t_col, col_start;
  logic [SXY_W-1:0]         sy, sx, sxy_start;
  logic [SIDX_W-1:0]        sidx;
  logic                     tap_in;
  logic [7:0]               centre;
  logic [ADDR_W-1:0]        w_addr;

  assign w_addr    = ADDR_W'(w_eff);
  assign col_start = (WIDTH_W+1)'(o_col) - (WIDTH_W+1)'(rad);
  assign sxy_start = SXY_W'(MAX_RADIUS) - SXY_W'(rad);
  assign sidx      = SIDX_W'(32'(sy) * KSIDE + 32'(sx));
  assign tap_in    = (t_row >= 0) && (t_row < $signed({1'b0, h_eff})) &&
                     (t_col >= 0) && (t_col < $signed({1'b0, w_eff}));
  assign line_rd_addr = cmd.start ? o_addr : tap_addr;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base  <= o_addr;
      t_row <= (ROW_W+2)'(o_row) - (ROW_W+2)'(rad);
      t_col <= col_start;
      sy    <= sxy_start;
      sx    <= sxy_start;
    end
    if (cmd.back_row) begin
      base <= mod_sub(base, w_addr);
    end
    if (cmd.back_col) begin
      row_addr <= mod_sub(base, ADDR_W'(rad));
      tap_addr <= mod_sub(base, ADDR_W'(rad));
    end
    if (cmd.tap) begin
      if (cmd.tap_row_end) begin
        t_row    <= t_row + (ROW_W+2)'(1);
        t_col    <= col_start;
        sy       <= sy + SXY_W'(1);
        sx       <= sxy_start;
        row_addr <= mod_add(row_addr, w_addr);
        tap_addr <= mod_add(row_addr, w_addr);
      end else begin
        t_col    <= t_col + (WIDTH_W+1)'(1);
        sx       <= sx + SXY_W'(1);
        tap_addr <= mod_add(tap_addr, ADDR_W'(1));
      end
    end
  end

  // Line store and weight tables.
  logic [7:0]  line_mem [LINE_DEPTH];
  logic [15:0] spat_mem [KSQ];
  logic [15:0] range_mem [RANGE_LEVELS];
  logic [7:0]  line_q;
  logic [15:0] spat_q, range_q;
  logic [7:0]  diff;

  always_ff @(posedge clk) begin
    if (pix_wr) begin
      line_mem[in_addr] <= item.pixel_value;
    end
    if (cmd.start || cmd.tap) begin
      line_q <= line_mem[line_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_SPATIAL && 32'(item.table_index) < KSQ) begin
      spat_mem[SIDX_W'(item.table_index)] <= item.weight_value;
    end
    spat_q <= spat_mem[sidx];
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_RANGE) begin
      range_mem[item.table_index] <= item.weight_value;
    end
    range_q <= range_mem[diff];
  end

  always_ff @(posedge clk) begin
    if (cmd.back_col) begin
      centre <= line_q;
    end
  end

  assign diff = (line_q > centre) ? line_q - centre : centre - line_q;

  // Multiply-accumulate pipeline.
  logic             valid1, valid2, valid3, valid4;
  logic [7:0]       v2, v3;
  logic [15:0]      s2;
  logic [31:0]      wt3;
  logic [39:0]      prod4;
  logic [TOT_W-1:0] tot;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] dvs;
  logic [7:0]       quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      valid1 <= cmd.tap && tap_in;
      valid2 <= valid1;
      valid3 <= valid2;
      valid4 <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    v2    <= line_q;
    s2    <= spat_q;
    wt3   <= 32'(s2) * 32'(range_q);
    v3    <= v2;
    prod4 <= 40'(wt3) * 40'(v3);
  end

  assign dvs = SUM_W'(tot) << cmd.div_bit;

  // Accumulators and one quotient bit per divide step.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tot <= '0;
      sum <= '0;
      quo <= '0;
    end else begin
      if (valid3) begin
        tot <= tot + TOT_W'(wt3);
      end
      if (valid4) begin
        sum <= sum + SUM_W'(prod4);
      end
      if (cmd.div_step) begin
        if (sum >= dvs) begin
          sum <= sum - dvs;
          quo <= {quo[6:0], 1'b1};
        end else begin
          quo <= {quo[6:0], 1'b0};
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.filtered_pixel <= (tot == '0) ? centre : quo;
      out_item.out_row        <= o_row;
      out_item.out_col        <= o_col[COL_W-1:0];
      out_item.frame_last     <= last;
    end
  end

endmodule

// ===== rtl/bilateral_filter_gray.sv =====
// Grayscale bilateral filter, raster-order stream in and out.
// A pixel or drain whose window is complete is taken through the single
// multiply-accumulate walk over the window, a pipeline flush and the
// 8-step divider, and no next item is taken until its result is handed off.
// Weight loads keep the controller in idle; items that release no pixel
// return to idle from the check state.
// Synchronous active-high reset; the line store and tables are not cleared.
module bilateral_filter_gray import bfg_pkg::*; #(
  parameter int MAX_RADIUS = 4,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  bfg_stream_if.sink       in_items,
  bfg_stream_if.source     out_items,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic       accept;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;
  in_item_t   in_item;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign in_item         = in_items.data;
  assign accept          = in_items.valid && in_ready;
  assign in_items.ready  = in_ready;
  assign out_items.valid = out_valid;
  assign out_items.data  = out_item;

  // Sequencer.
  bfg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .accept_kind (in_item.kind),
    .status      (status),
    .cmd         (cmd),
    .in_ready    (in_ready)
  );

  // Storage and arithmetic.
  bfg_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_items.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> !status.out_block)
    else $error("result loaded over a waiting transaction");

  // No input transaction while the window walk or divider is busy.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> !(cmd.tap || cmd.div_step || cmd.start))
    else $error("input accepted during filtering");

  // A new output transaction appears only after an emit command.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid without emit");
`endif

endmodule

// ===== dv/tb.sv =====
// Testbench for the streaming grayscale bilateral filter.
// Depends on rtl/bfg_pkg.sv, rtl/bfg_stream_if.sv and rtl/bilateral_filter_gray.sv.
`timescale 1ns / 1ps

module tb;
  import bfg_pkg::*;

  localparam int KSIDE      = 9;
  localparam int KTAPS      = KSIDE * KSIDE;
  localparam int RING_DEPTH = KSIDE * 1024;
  localparam int SETTLE_CYC = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [1:0]       cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;

  bfg_stream_if #(.T(in_item_t))  in_if ();
  bfg_stream_if #(.T(out_item_t)) out_if ();

  bilateral_filter_gray dut (
    .clk       (clk),
    .rst       (rst),
    .in_items  (in_if),
    .out_items (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow state of the filter.
  logic [10:0] img_width  = 11'd640;
  logic [12:0] img_height = 13'd480;
  logic [2:0]  win_radius = 3'd2;
  logic [7:0]  pixel_ring [RING_DEPTH];
  logic [15:0] spatial_tab [KTAPS];
  logic [15:0] range_tab [256];
  int unsigned in_row, in_col, next_out;
  bit          frame_in;

  out_item_t pixels_due [$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        calm = 1'b0;

  function automatic int unsigned eff_width();
    if (img_width == 0) return 1;
    return (img_width > 1024) ? 1024 : img_width;
  endfunction

  function automatic int unsigned eff_height();
    if (img_height == 0) return 1;
    return (img_height > MAX_HEIGHT) ? MAX_HEIGHT : img_height;
  endfunction

  function automatic int unsigned eff_radius();
    return (win_radius > 4) ? 4 : win_radius;
  endfunction

  function automatic void restart_frame();
    in_row   = 0;
    in_col   = 0;
    next_out = 0;
    frame_in = 1'b0;
  endfunction

  // Weighted mean over the window around (r, c); taps off the image are skipped.
  function automatic logic [7:0] filter_at(int r, int c, int w, int h, int rad);
    longint unsigned acc, total, wt;
    int tr, tc;
    logic [7:0] centre, v, diff;
    acc = 0;
    total = 0;
    centre = pixel_ring[(r * w + c) % RING_DEPTH];
    for (int dy = -rad; dy <= rad; dy++) begin
      tr = r + dy;
      if (tr < 0 || tr >= h) continue;
      for (int dx = -rad; dx <= rad; dx++) begin
        tc = c + dx;
        if (tc < 0 || tc >= w) continue;
        v = pixel_ring[(tr * w + tc) % RING_DEPTH];
        diff = (v > centre) ? v - centre : centre - v;
        wt = longint'(spatial_tab[(dy + 4) * KSIDE + dx + 4]) * range_tab[diff];
        total += wt;
        acc += wt * v;
      end
    end
    if (total == 0) return centre;
    acc = acc / total;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  // Releases the next pixel once its window is complete.
  function automatic void release_ready();
    int unsigned w, h, rad, cnt, r, c, lr, lc;
    out_item_t o;
    w = eff_width();
    h = eff_height();
    rad = eff_radius();
    cnt = w * h;
    if (next_out >= cnt) begin
      restart_frame();
      return;
    end
    r = next_out / w;
    c = next_out % w;
    if (!frame_in) begin
      lr = (r + rad > h - 1) ? h - 1 : r + rad;
      lc = (c + rad > w - 1) ? w - 1 : c + rad;
      if (lr * w + lc >= in_row * w + in_col) return;
    end
    o.filtered_pixel = filter_at(r, c, w, h, rad);
    o.out_row = r[ROW_W-1:0];
    o.out_col = c[COL_W-1:0];
    o.frame_last = (next_out == cnt - 1);
    pixels_due.push_back(o);
    if (o.frame_last) restart_frame();
    else next_out++;
  endfunction

  function automatic void model_accept(in_item_t it);
    int unsigned w, h;
    case (it.kind)
      KIND_SPATIAL: begin
        if (it.table_index < KTAPS) spatial_tab[it.table_index] = it.weight_value;
      end
      KIND_RANGE: range_tab[it.table_index] = it.weight_value;
      default: begin
        if (it.kind == KIND_PIXEL && !frame_in) begin
          w = eff_width();
          h = eff_height();
          if (in_col >= w || in_row >= h) restart_frame();
          pixel_ring[(in_row * w + in_col) % RING_DEPTH] = it.pixel_value;
          in_col++;
          if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
              in_row = 0;
              frame_in = 1'b1;
            end
          end
        end
        release_ready();
      end
    endcase
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 24);
  endfunction

  // Sends one item, with random idle cycles ahead of it.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while (idle_now()) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    model_accept(it);
    items_sent++;
  endtask

  task automatic send_kind(kind_t k, logic [7:0] pix, logic [7:0] idx, logic [15:0] wv);
    in_item_t it;
    it.kind = k;
    it.pixel_value = pix;
    it.table_index = idx;
    it.weight_value = wv;
    send_item(it);
  endtask

  // Stops sending and waits until every expected pixel has come out.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (pixels_due.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_WIDTH:  img_width  = value[10:0];
      REG_HEIGHT: img_height = value[12:0];
      REG_RADIUS: win_radius = value[2:0];
      default: ;
    endcase
    if (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_RADIUS) restart_frame();
  endtask

  task automatic set_frame(int w, int h, int rad);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, rad);
  endtask

  // Flushes the rest of a fully received frame.
  task automatic drain_frame();
    while (frame_in) send_kind(KIND_DRAIN, $urandom, $urandom, $urandom);
  endtask

  task automatic send_frame(int extremes);
    int n;
    n = eff_width() * eff_height();
    for (int i = 0; i < n; i++)
      send_kind(KIND_PIXEL, extremes ? ((i % 3 == 0) ? 8'd0 : 8'd255) : $urandom,
                $urandom, $urandom);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Receiver side: random backpressure, always ready while calm.
  always @(negedge clk) out_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);

  // Compare each output transaction with the oldest expected pixel.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pixels_due.size() == 0) begin
        report("unexpected pixel at row", out_if.data.out_row, 0);
      end else begin
        want = pixels_due.pop_front();
        if (out_if.data.filtered_pixel !== want.filtered_pixel)
          report("filtered_pixel", out_if.data.filtered_pixel, want.filtered_pixel);
        if (out_if.data.out_row !== want.out_row)
          report("out_row", out_if.data.out_row, want.out_row);
        if (out_if.data.out_col !== want.out_col)
          report("out_col", out_if.data.out_col, want.out_col);
        if (out_if.data.frame_last !== want.frame_last)
          report("frame_last", out_if.data.frame_last, want.frame_last);
      end
    end
  end

  // Fill both tables, including extreme weights and ignored spatial slots.
  task automatic test_table_load();
    for (int i = 0; i < KTAPS; i++)
      send_kind(KIND_SPATIAL, $urandom, i, (i == 0) ? 16'd32768 :
                (i == 1) ? 16'hFFFF : (i == 2) ? 16'd0 : $urandom);
    for (int i = 0; i < 256; i++)
      send_kind(KIND_RANGE, $urandom, i, (i == 0) ? 16'hFFFF : (i == 255) ? 16'd0 : $urandom);
    send_kind(KIND_SPATIAL, 8'hFF, 8'd81, 16'hFFFF);
    send_kind(KIND_SPATIAL, 8'h00, 8'd255, 16'h0000);
  endtask

  task automatic test_small_frame();
    set_frame(4, 3, 1);
    send_frame(1);
    drain_frame();
    send_kind(KIND_DRAIN, 0, 0, 0);
  endtask

  // A zero centre weight at radius 0 makes every pixel pass straight through.
  task automatic test_zero_weight();
    set_frame(3, 2, 0);
    send_kind(KIND_SPATIAL, 0, 8'd40, 16'd0);
    send_frame(0);
    drain_frame();
    send_kind(KIND_SPATIAL, 0, 8'd40, 16'd32768);
  endtask

  task automatic test_single_pixel();
    set_frame(0, 0, 7);
    send_kind(KIND_PIXEL, 8'd200, 0, 0);
  endtask

  // Pixels sent after the whole frame is in act as drains.
  task automatic test_pixel_after_end();
    set_frame(3, 3, 2);
    send_frame(0);
    while (frame_in) send_kind(KIND_PIXEL, $urandom, $urandom, $urandom);
  endtask

  // Oversized registers saturate; only the head of the frame is sent.
  task automatic test_wide_partial();
    set_frame(2047, 8191, 1);
    for (int i = 0; i < 12; i++) send_kind(KIND_PIXEL, $urandom, 0, 0);
    send_kind(KIND_DRAIN, 0, 0, 0);
    set_frame(1024, 1, 0);
    for (int i = 0; i < 6; i++) send_kind(KIND_PIXEL, $urandom, 0, 0);
  endtask

  // Random frames with stray loads, drains and frames cut short.
  task automatic test_random_frames();
    int frame_no, n, cut;
    frame_no = 0;
    while (items_sent < 1150) begin
      calm = (frame_no >= 6 && frame_no < 10);
      set_frame($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 12),
                $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 7),
                $urandom_range(0, 7));
      n = eff_width() * eff_height();
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < cut; i++) begin
        if (frame_no == 3 && i == n / 2) settle();
        if ($urandom_range(0, 99) < 6) begin
          case ($urandom_range(0, 2))
            0: send_kind(KIND_SPATIAL, $urandom, $urandom, $urandom);
            1: send_kind(KIND_RANGE, $urandom, $urandom, $urandom);
            default: send_kind(KIND_DRAIN, $urandom, $urandom, $urandom);
          endcase
        end
        send_kind(KIND_PIXEL, $urandom, $urandom, $urandom);
      end
      if (cut == n) drain_frame();
      frame_no++;
    end
    calm = 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
    restart_frame();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_table_load();
    test_small_frame();
    test_zero_weight();
    test_single_pixel();
    test_pixel_after_end();
    test_wide_partial();
    test_random_frames();
    settle();
    if (mismatches == 0) $display("[bilateral_filter_gray] OK");
    else $display("[bilateral_filter_gray] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[bilateral_filter_gray] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bfg_pkg.sv
rtl/bfg_stream_if.sv
rtl/bfg_ctrl.sv
rtl/bfg_datapath.sv
rtl/bilateral_filter_gray.sv
dv/tb.sv
